FILE: rtl/core/ftsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftsr_pkg : shared types and constants of the frame table
// Field widths, default sizing and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package ftsr_pkg;

   localparam int MAX_FRAMES_DEFAULT = 64;
   localparam int STAMP_BITS_DEFAULT = 32;

   localparam int PID_W    = 16;
   localparam int SEG_W    = 12;
   localparam int PAGE_W   = 12;
   localparam int FRAME_W  = 6;
   localparam int CFG_W    = 7;

   localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 7'd64;

   // identity of one resident page
   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [SEG_W-1:0]  segment;
      logic [PAGE_W-1:0] page;
   } key_type;

   // search progress carried from cell to cell
   typedef struct packed {
      logic valid;
      logic hit;
      logic free;
      logic have_min;
   } scan_flags_type;

   // write-back command broadcast to all cells
   typedef struct packed {
      logic en;
      logic fill;
   } wr_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/ftsr_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftsr_req_if : access request channel
// Valid/ready channel carrying one page access (pid, segment, page).
// ----------------------------------------------------------------------------
interface ftsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftsr_pkg::PID_W-1:0]  pid;
   logic [ftsr_pkg::SEG_W-1:0]  segment;
   logic [ftsr_pkg::PAGE_W-1:0] page;

   modport source (output valid, output pid, output segment, output page, input ready);
   modport sink   (input valid, input pid, input segment, input page, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ftsr_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftsr_rsp_if : allocation result channel
// Valid/ready channel carrying the frame chosen and the eviction report.
// ----------------------------------------------------------------------------
interface ftsr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ftsr_pkg::FRAME_W-1:0] frame;
   logic                         hit;
   logic                         evicted;
   logic [ftsr_pkg::PID_W-1:0]   victim_pid;
   logic [ftsr_pkg::SEG_W-1:0]   victim_segment;
   logic [ftsr_pkg::PAGE_W-1:0]  victim_page;

   modport source (output valid, output frame, output hit, output evicted,
                   output victim_pid, output victim_segment, output victim_page,
                   input ready);
   modport sink   (input valid, input frame, input hit, input evicted,
                   input victim_pid, input victim_segment, input victim_page,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ftsr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftsr_cell : one frame of the frame table
// Holds busy, page identity and stamp of one frame; folds its frame into the
// passing search packet and takes write-back commands addressed to it.
// ----------------------------------------------------------------------------
module ftsr_cell #(
   parameter int IDX_W      = 6,
   parameter int STAMP_BITS = ftsr_pkg::STAMP_BITS_DEFAULT,
   parameter int IDX        = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        active,
   input  ftsr_pkg::key_type          key,
   input  ftsr_pkg::scan_flags_type   in_flags,
   input  wire [IDX_W-1:0]            in_hit_idx,
   input  wire [IDX_W-1:0]            in_free_idx,
   input  wire [IDX_W-1:0]            in_min_idx,
   input  wire [STAMP_BITS-1:0]       in_min_stamp,
   input  ftsr_pkg::key_type          in_min_key,
   output ftsr_pkg::scan_flags_type   out_flags,
   output logic [IDX_W-1:0]           out_hit_idx,
   output logic [IDX_W-1:0]           out_free_idx,
   output logic [IDX_W-1:0]           out_min_idx,
   output logic [STAMP_BITS-1:0]      out_min_stamp,
   output ftsr_pkg::key_type          out_min_key,
   input  ftsr_pkg::wr_ctl_type       wr_ctl,
   input  wire [IDX_W-1:0]            wr_idx,
   input  wire [STAMP_BITS-1:0]       wr_stamp
);
   import ftsr_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                  busy_ff;
   key_type               key_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   scan_flags_type        flags_ff,     flags_in;
   logic [IDX_W-1:0]      hit_idx_ff,   hit_idx_in;
   logic [IDX_W-1:0]      free_idx_ff,  free_idx_in;
   logic [IDX_W-1:0]      min_idx_ff,   min_idx_in;
   logic [STAMP_BITS-1:0] min_stamp_ff, min_stamp_in;
   key_type               min_key_ff,   min_key_in;

   logic take_hit, take_free, take_min, wr_mine;

   assign take_hit  = active && !in_flags.hit && busy_ff && (key_ff == key);
   assign take_free = active && !in_flags.free && !busy_ff;
   // victim seed comes from occupied frames only
   assign take_min  = active && busy_ff && (!in_flags.have_min || (stamp_ff < in_min_stamp));
   assign wr_mine   = wr_ctl.en && (wr_idx == MY_IDX);

   always_comb begin
      flags_in          = in_flags;
      flags_in.hit      = in_flags.hit      || take_hit;
      flags_in.free     = in_flags.free     || take_free;
      flags_in.have_min = in_flags.have_min || take_min;
      hit_idx_in        = take_hit  ? MY_IDX   : in_hit_idx;
      free_idx_in       = take_free ? MY_IDX   : in_free_idx;
      min_idx_in        = take_min  ? MY_IDX   : in_min_idx;
      min_stamp_in      = take_min  ? stamp_ff : in_min_stamp;
      min_key_in        = take_min  ? key_ff   : in_min_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // packet payload loads only with a valid packet and holds afterward
   always_ff @(posedge clock) begin
      if (in_flags.valid) begin
         hit_idx_ff   <= hit_idx_in;
         free_idx_ff  <= free_idx_in;
         min_idx_ff   <= min_idx_in;
         min_stamp_ff <= min_stamp_in;
         min_key_ff   <= min_key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         stamp_ff <= '0;
      end else if (wr_mine) begin
         stamp_ff <= wr_stamp;
         if (wr_ctl.fill) begin
            busy_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mine && wr_ctl.fill) begin
         key_ff <= key;
      end
   end

   assign out_flags     = flags_ff;
   assign out_hit_idx   = hit_idx_ff;
   assign out_free_idx  = free_idx_ff;
   assign out_min_idx   = min_idx_ff;
   assign out_min_stamp = min_stamp_ff;
   assign out_min_key   = min_key_ff;

endmodule
`default_nettype wire

FILE: rtl/core/frame_table_stamp_replacement_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_table_stamp_replacement_unit : physical frame table, stamp replacement
// Looks up a page access, allocates a free frame or evicts the oldest stamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  : one page access item (pid, segment, page), valid/ready.
//   rsp_chan  : one result item per access: frame, hit, evicted and the
//               evicted page's identity (zero when nothing was evicted).
//   csr_we / csr_wdata : frame_count register, to be written only while idle;
//               the block does not enforce this. Zero acts as one frame, values above MAX_FRAMES saturate.
// Structure: a row of MAX_FRAMES cells, one per frame. A search packet walks
//   the row one cell per cycle, collecting first hit, first free frame and
//   the minimum stamp among occupied frames. The controller then broadcasts
//   a write-back (new stamp, and page identity on a miss) to the target cell.
// Sequence: after accept the packet walks the row, then the write-back and the
//   result register load follow in DONE; no new item is taken until idle again.
// Reset: every frame free, all stamps and the stamp counter zero,
//   frame_count = 64.
// Stall: a result waiting in the output register does not block acceptance
//   of the next item; that item's scan runs, and its write-back and result
//   wait until the output register is taken.
// ----------------------------------------------------------------------------
module frame_table_stamp_replacement_unit #(
   parameter int MAX_FRAMES = ftsr_pkg::MAX_FRAMES_DEFAULT,
   parameter int STAMP_BITS = ftsr_pkg::STAMP_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   ftsr_req_if.sink                   req_chan,
   ftsr_rsp_if.source                 rsp_chan,
   input  wire                        csr_we,
   input  wire [ftsr_pkg::CFG_W-1:0]  csr_wdata
);
   import ftsr_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CFG_W-1:0]      count_ff;
   logic [CNT_W-1:0]      n_eff;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   key_type               key_ff;
   logic                  start_ff;

   logic                  accept, out_free, finish;

   // chain taps: index 0 is the injected packet, index i+1 leaves cell i
   scan_flags_type        c_flags     [MAX_FRAMES+1];
   logic [IDX_W-1:0]      c_hit_idx   [MAX_FRAMES+1];
   logic [IDX_W-1:0]      c_free_idx  [MAX_FRAMES+1];
   logic [IDX_W-1:0]      c_min_idx   [MAX_FRAMES+1];
   logic [STAMP_BITS-1:0] c_min_stamp [MAX_FRAMES+1];
   key_type               c_min_key   [MAX_FRAMES+1];
   logic [MAX_FRAMES-1:0] active;

   wr_ctl_type            wr_ctl;
   logic [IDX_W-1:0]      wr_idx;

   // result output register
   logic                  rsp_valid_ff;
   logic [FRAME_W-1:0]    rsp_frame_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_evicted_ff;
   key_type               rsp_victim_ff;

   // decision taken from the packet leaving the last cell
   scan_flags_type        last_flags;
   logic                  miss_fill, do_evict;
   key_type               victim_key;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == ST_DONE) && out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // frames in use, clamped to 1..MAX_FRAMES
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_FRAMES)) begin
         n_eff = CNT_W'(MAX_FRAMES);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= FRAME_COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_flags.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff.pid     <= req_chan.pid;
         key_ff.segment <= req_chan.segment;
         key_ff.page    <= req_chan.page;
      end
   end

   // packet injection: empty search, launched the cycle after accept
   always_comb begin
      c_flags[0]       = '0;
      c_flags[0].valid = start_ff;
      c_hit_idx[0]     = '0;
      c_free_idx[0]    = '0;
      c_min_idx[0]     = '0;
      c_min_stamp[0]   = '0;
      c_min_key[0]     = '0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
         assign active[gi] = (CNT_W'(gi) < n_eff);

         ftsr_cell #(
            .IDX_W      (IDX_W),
            .STAMP_BITS (STAMP_BITS),
            .IDX        (gi)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .active        (active[gi]),
            .key           (key_ff),
            .in_flags      (c_flags[gi]),
            .in_hit_idx    (c_hit_idx[gi]),
            .in_free_idx   (c_free_idx[gi]),
            .in_min_idx    (c_min_idx[gi]),
            .in_min_stamp  (c_min_stamp[gi]),
            .in_min_key    (c_min_key[gi]),
            .out_flags     (c_flags[gi+1]),
            .out_hit_idx   (c_hit_idx[gi+1]),
            .out_free_idx  (c_free_idx[gi+1]),
            .out_min_idx   (c_min_idx[gi+1]),
            .out_min_stamp (c_min_stamp[gi+1]),
            .out_min_key   (c_min_key[gi+1]),
            .wr_ctl        (wr_ctl),
            .wr_idx        (wr_idx),
            .wr_stamp      (stamp_in)
         );
      end
   endgenerate

   // last cell's packet holds its payload until the next scan
   assign last_flags = c_flags[MAX_FRAMES];
   assign miss_fill  = !last_flags.hit;
   assign do_evict   = !last_flags.hit && !last_flags.free;
   assign victim_key = do_evict ? c_min_key[MAX_FRAMES] : '0;

   always_comb begin
      if (last_flags.hit) begin
         wr_idx = c_hit_idx[MAX_FRAMES];
      end else if (last_flags.free) begin
         wr_idx = c_free_idx[MAX_FRAMES];
      end else begin
         wr_idx = c_min_idx[MAX_FRAMES];
      end
   end

   always_comb begin
      wr_ctl.en   = finish;
      wr_ctl.fill = miss_fill;
   end

   // stamp counter saturates at all ones
   assign stamp_in = (stamp_ff == '1) ? stamp_ff : stamp_ff + STAMP_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else if (finish) begin
         stamp_ff <= stamp_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_frame_ff   <= FRAME_W'(wr_idx);
         rsp_hit_ff     <= last_flags.hit;
         rsp_evicted_ff <= do_evict;
         rsp_victim_ff  <= victim_key;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.frame          = rsp_frame_ff;
   assign rsp_chan.hit            = rsp_hit_ff;
   assign rsp_chan.evicted        = rsp_evicted_ff;
   assign rsp_chan.victim_pid     = rsp_victim_ff.pid;
   assign rsp_chan.victim_segment = rsp_victim_ff.segment;
   assign rsp_chan.victim_page    = rsp_victim_ff.page;

endmodule
`default_nettype wire

FILE: verif/ftsr_frame_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftsr_frame_check : frame table predictor and result checker
// Watches both channels and the frame_count port. Keeps its own frame
// table, places each accepted access, and compares each result item with
// the oldest placement still waiting.
// ----------------------------------------------------------------------------
module ftsr_frame_check #(
   parameter int MAX_FRAMES = ftsr_pkg::MAX_FRAMES_DEFAULT,
   parameter int STAMP_BITS = ftsr_pkg::STAMP_BITS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   ftsr_req_if                         req_mon,
   ftsr_rsp_if                         rsp_mon,
   input  wire                         csr_we,
   input  wire [ftsr_pkg::CFG_W-1:0]   csr_wdata,
   output int unsigned                 pending_count,
   output int unsigned                 mismatch_count,
   output int unsigned                 access_count,
   output int unsigned                 hit_count,
   output int unsigned                 evict_count
);
   import ftsr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               hit;
      logic               evicted;
      key_type            victim;
   } placement_type;

   logic                  busy [MAX_FRAMES];
   key_type               resident [MAX_FRAMES];
   logic [STAMP_BITS-1:0] stamp [MAX_FRAMES];
   logic [STAMP_BITS-1:0] stamp_now;
   logic [CFG_W-1:0]      frames_cfg;
   placement_type         placement_q[$];

   // place one access in the table and return the result it must produce
   function automatic placement_type place_access(key_type k);
      int            n;
      int            f;
      int            slot;
      bit            found;
      placement_type r;
      r = '0;
      n = (frames_cfg == 0) ? 1 : (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
      found = 1'b0;
      slot = 0;
      for (f = 0; f < n && !found; f++) begin
         if (busy[f] && resident[f] == k) begin
            slot = f;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
      end else begin
         for (f = 0; f < n && !found; f++) begin
            if (!busy[f]) begin
               slot = f;
               found = 1'b1;
            end
         end
         if (!found) begin
            // every frame in use is taken: oldest stamp goes, lowest index on ties
            slot = 0;
            for (f = 1; f < n; f++) begin
               if (stamp[f] < stamp[slot]) slot = f;
            end
            r.evicted = 1'b1;
            r.victim = resident[slot];
         end
         busy[slot] = 1'b1;
         resident[slot] = k;
      end
      if (stamp_now != '1) stamp_now++;
      stamp[slot] = stamp_now;
      r.frame = slot[FRAME_W-1:0];
      return r;
   endfunction

   task automatic check_result();
      placement_type want;
      placement_type got;
      got.frame = rsp_mon.frame;
      got.hit = rsp_mon.hit;
      got.evicted = rsp_mon.evicted;
      got.victim = {rsp_mon.victim_pid, rsp_mon.victim_segment, rsp_mon.victim_page};
      if (placement_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result item with no access waiting: frame %0d", $realtime, got.frame);
         return;
      end
      want = placement_q.pop_front();
      if (got.frame !== want.frame || got.hit !== want.hit || got.evicted !== want.evicted ||
          got.victim.pid !== want.victim.pid || got.victim.segment !== want.victim.segment ||
          got.victim.page !== want.victim.page) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $realtime);
            $display("   expected frame %0d hit %0b evicted %0b victim %h/%h/%h", want.frame,
                     want.hit, want.evicted, want.victim.pid, want.victim.segment,
                     want.victim.page);
            $display("   actual   frame %0d hit %0b evicted %0b victim %h/%h/%h", got.frame,
                     got.hit, got.evicted, got.victim.pid, got.victim.segment,
                     got.victim.page);
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      access_count = 0;
      hit_count = 0;
      evict_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      placement_type p;
      if (reset) begin
         for (int f = 0; f < MAX_FRAMES; f++) begin
            busy[f] = 1'b0;
            resident[f] = '0;
            stamp[f] = '0;
         end
         stamp_now = '0;
         frames_cfg = FRAME_COUNT_RESET;
         placement_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_we) frames_cfg = csr_wdata;
         // a result always belongs to an earlier access, so check before placing
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) begin
            p = place_access({req_mon.pid, req_mon.segment, req_mon.page});
            placement_q.push_back(p);
            access_count++;
            if (p.hit) hit_count++;
            if (p.evicted) evict_count++;
         end
         pending_count <= placement_q.size();
      end
   end

endmodule

FILE: verif/tb_frame_table_stamp_replacement_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_table_stamp_replacement_unit : frame table testbench top
// Drives page accesses and frame_count settings into the frame table, with
// bursty sending and a stalling receiver. The checker beside the block
// predicts every result item; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module tb_frame_table_stamp_replacement_unit;
   import ftsr_pkg::*;

   localparam int MAX_FRAMES      = MAX_FRAMES_DEFAULT;
   localparam int STAMP_BITS      = STAMP_BITS_DEFAULT;
   localparam int RESULT_LATENCY  = MAX_FRAMES + 2;   // accept to result
   localparam int RSP_HOLD_CYCLES = 400;              // long receiver hold-off
   localparam int IDLE_LIMIT      = 4000;             // cycles with no handshake at all
   localparam int PHASE_ITEMS     = 170;
   localparam int POOL_DEPTH      = 128;

   // frame_count settings of the random phases: extremes, zero and over-range
   // values, and small tables that force evictions
   localparam int NUM_PHASES = 11;
   localparam logic [CFG_W-1:0] PHASE_SETTING [NUM_PHASES] =
      '{7'd64, 7'd1, 7'd3, 7'd8, 7'd127, 7'd2, 7'd40, 7'd0, 7'd16, 7'd100, 7'd64};

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   int unsigned pending_count;
   int unsigned mismatch_count;
   int unsigned access_count;
   int unsigned hit_count;
   int unsigned evict_count;

   int unsigned hold_requests = 0;   // bumped by the sender, served by the receiver
   int unsigned drain_count = 0;
   int unsigned setting_count = 0;
   int unsigned idle_cycles = 0;

   ftsr_req_if req_chan();
   ftsr_rsp_if rsp_chan();

   frame_table_stamp_replacement_unit #(
      .MAX_FRAMES (MAX_FRAMES),
      .STAMP_BITS (STAMP_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ftsr_frame_check #(
      .MAX_FRAMES (MAX_FRAMES),
      .STAMP_BITS (STAMP_BITS)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count),
      .access_count   (access_count),
      .hit_count      (hit_count),
      .evict_count    (evict_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Sender helpers. Everything is driven with NBAs right after the edge;
   // handshakes are read right after the edge too, so they see the values
   // that were present at the edge.
   // ---------------------------------------------------------------------

   // offer one access and hold it until the block takes it
   task automatic send_access(input key_type k);
      req_chan.valid <= 1'b1;
      req_chan.pid <= k.pid;
      req_chan.segment <= k.segment;
      req_chan.page <= k.page;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // gap between bursts; a zero gap keeps valid high for back-to-back items
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // frame_count only changes while the block is idle
   task automatic write_frame_count(input logic [CFG_W-1:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: switches at random between stall patterns (always
   // ready, mostly ready, periodic, mostly stalled). A hold request from the
   // sender drops ready for a long counted stretch so the block backs up.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned stall_cycle;
      int unsigned stall_mode;
      int unsigned holds_done;
      stall_cycle = 0;
      stall_mode = 0;
      holds_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_cycle++;
         if (stall_cycle % 700 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_requests != holds_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_chan.ready <= 1'b1;
               end
               1: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_chan.ready <= (stall_cycle % 5 >= 2);
               end
               default: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any cycle with no handshake on either channel counts; a long
   // enough run of them means the block hung.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_count);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      key_type access_pool [POOL_DEPTH];
      key_type k;
      int      pool_size;
      int      frames_eff;
      int      sent;
      int      burst;
      int      pick;
      bit      drained_mid;

      req_chan.valid <= 1'b0;
      req_chan.pid <= '0;
      req_chan.segment <= '0;
      req_chan.page <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, full table after reset (64 frames) ---
      send_access({16'hFFFF, 12'hFFF, 12'hFFF});   // all-ones key, frame 0
      send_access({16'h0000, 12'h000, 12'h000});   // pid zero is an ordinary owner
      send_access({16'h0000, 12'h000, 12'h000});   // hit on the pid zero page
      pause_sender(3);
      send_access({16'h0001, 12'h000, 12'h000});
      send_access({16'hFFFF, 12'hFFF, 12'hFFF});   // hit, re-stamps frame 0
      send_access({16'hFFFF, 12'hFFF, 12'hFFE});   // differs in the last page bit: miss

      // two frames, both busy: oldest stamp goes
      write_frame_count(7'd2);
      send_access({16'h8000, 12'h800, 12'h800});
      send_access({16'h8000, 12'h800, 12'h800});
      send_access({16'h5555, 12'hAAA, 12'h555});

      // zero acts as a single frame; frames above it keep their pages
      write_frame_count(7'd0);
      send_access({16'hAAAA, 12'h555, 12'hAAA});
      send_access({16'hAAAA, 12'h555, 12'hAAA});
      send_access({16'h0001, 12'h000, 12'h000});   // also parked in frame 2, not visible

      // over-range count saturates; the parked copy reappears as a duplicate,
      // lowest frame must win
      write_frame_count(7'd127);
      send_access({16'h0001, 12'h000, 12'h000});
      send_access({16'hFFFF, 12'hFFF, 12'hFFE});   // kept from the first setting
      send_access({16'h1234, 12'hABC, 12'hDEF});   // next free frame

      // --- random phases ---
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_frame_count(PHASE_SETTING[p]);
         frames_eff = (PHASE_SETTING[p] == 0) ? 1 :
                      (PHASE_SETTING[p] > MAX_FRAMES) ? MAX_FRAMES : int'(PHASE_SETTING[p]);

         // working set a little larger than the table, so hits and
         // evictions both happen often
         pool_size = frames_eff + $urandom_range(1, frames_eff / 2 + 3);
         for (int i = 0; i < pool_size; i++) begin
            access_pool[i].pid = ($urandom_range(0, 15) == 0) ? 16'h0000
                                                               : 16'($urandom_range(1, 16'hFFFF));
            access_pool[i].segment = 12'($urandom_range(0, 12'hFFF));
            access_pool[i].page = 12'($urandom_range(0, 12'hFFF));
         end

         sent = 0;
         drained_mid = 1'b0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            // long receiver hold-off while the sender keeps offering items
            if ((p == 4 || p == 9) && sent == 0) begin
               hold_requests++;
               burst = 10;
            end
            repeat (burst) begin
               pick = $urandom_range(0, 99);
               if (pick < 80) begin
                  k = access_pool[$urandom_range(0, pool_size - 1)];
               end else if (pick < 90) begin
                  // near miss: one bit off a resident-looking key
                  k = access_pool[$urandom_range(0, pool_size - 1)] ^
                      (40'd1 << $urandom_range(0, 39));
               end else begin
                  k.pid = 16'($urandom_range(0, 16'hFFFF));
                  k.segment = 12'($urandom_range(0, 12'hFFF));
                  k.page = 12'($urandom_range(0, 12'hFFF));
               end
               send_access(k);
               sent++;
            end
            if (!drained_mid && sent >= PHASE_ITEMS / 2) begin
               // sender pause until the block has emptied
               wait_drained();
               drain_count++;
               drained_mid = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
               pause_sender(0);
            end else begin
               pause_sender($urandom_range(1, 90));
            end
         end
      end

      // --- wind down ---
      wait_drained();
      repeat (RESULT_LATENCY + 8) @(posedge clock);

      $display("Run covered %0d accesses over %0d frame_count settings: %0d hits, %0d evictions.",
               access_count, setting_count, hit_count, evict_count);
      $display("Long receiver hold-offs: %0d, mid-phase sender drains: %0d, mismatches: %0d.",
               hold_requests, drain_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/ftsr_pkg.sv
rtl/core/ftsr_req_if.sv
rtl/core/ftsr_rsp_if.sv
rtl/core/ftsr_cell.sv
rtl/core/frame_table_stamp_replacement_unit.sv
verif/ftsr_frame_check.sv
verif/tb_frame_table_stamp_replacement_unit.sv
